/* hdl/lkvc_pkg.sv */
// Package for the LRU key/value cache: field widths, the word moved along
// the row of cells, the summary carried back along it, and the cell control.
// No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 5;
    localparam int DEF_ENTRIES = 16;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // One stored entry, also the word a cell hands to its right neighbour
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_entry;

    // Summary gathered from the tail of the row towards the head
    typedef struct packed {
        logic             any;      // a match at this cell or further right
        logic             next_vld; // valid bit of the cell just to the right
        logic [VAL_W-1:0] rd;       // value of the matching cell
        logic [KEY_W-1:0] lkey;     // key of the last valid (oldest) cell
    } t_chain;

    // How the row shifts on an update
    typedef enum logic [1:0] {
        MODE_HIT,   // matched entry moves to the head
        MODE_INS,   // new entry at the head, row grows by one
        MODE_EVICT  // new entry at the head, oldest entry drops off
    } t_mode;

    typedef struct packed {
        logic             cmp;  // register key compare this cycle
        logic             upd;  // shift the row this cycle
        t_mode            mode;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

/* hdl/lru_key_value_cache.sv */
// Top level of the LRU key/value cache: command channel, capacity register,
// sequencer and the row of cells. Depends on lkvc_pkg and lkvc_cell.
`timescale 1ns / 1ps
//
// Usage
//   Command: drive i_op (0 get, 1 put), i_key, i_value with start; the word
//   is taken at a rising edge where start is high and busy is low.
//   Result: o_hit, o_read_value, o_evicted, o_evicted_key are valid for the
//   single cycle o_strobe is high. The receiver cannot hold results off.
//   Capacity: i_cfg_active_entries is written when i_cfg_valid and
//   o_cfg_ready are both high; o_cfg_ready is always high. Write only while
//   the cache is idle. 0 acts as 1, values above ENTRIES act as ENTRIES.
// Operation
//   Entries sit in a row of cells ordered by recency, most recent at the
//   head. Each item first compares all cells against the key, then shifts
//   the row unless it is a get that misses, and its result is registered
//   then. A new command can be taken while the previous one shifts the row.
// Reset
//   Synchronous, active low: the cache empties, capacity returns to 16,
//   no result is pending.

module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_op,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_strobe,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_evicted,
    output logic signed [KEY_W-1:0] o_evicted_key,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic        [CFG_W-1:0] i_cfg_active_entries
);

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CAP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} t_state;

    t_state           r_state;
    logic             r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CFG_W-1:0] r_cfg;
    logic [FILL_W-1:0] r_fill;
    logic             r_strobe;
    logic             r_hit;
    logic [VAL_W-1:0] r_rd;
    logic             r_ev;
    logic [KEY_W-1:0] r_evk;

    logic [CAP_W-1:0] w_cfg_ext;
    logic [CAP_W-1:0] w_cap;
    logic             w_room;
    logic             w_accept;
    logic             w_hit;
    t_mode            w_mode;
    t_cell_ctl        w_ctl;
    t_entry           w_head;
    t_entry           w_ent [ENTRIES];
    t_chain           w_ch  [ENTRIES+1];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_vld;

    assign busy        = (r_state == S_CMP);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_active_entries;
        end
    end

    // Effective capacity, clipped to 1..ENTRIES
    assign w_cfg_ext = CAP_W'(r_cfg);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_cap = CAP_W'(1);
        end else if (w_cfg_ext > CAP_W'(ENTRIES)) begin
            w_cap = CAP_W'(ENTRIES);
        end else begin
            w_cap = w_cfg_ext;
        end
    end
    assign w_room = CAP_W'(r_fill) < w_cap;

    // Update decision from the registered compare
    assign w_hit = w_ch[0].any;
    always_comb begin
        if (w_hit) begin
            w_mode = MODE_HIT;
        end else if (w_room) begin
            w_mode = MODE_INS;
        end else begin
            w_mode = MODE_EVICT;
        end
    end

    assign w_ctl.cmp  = (r_state == S_CMP);
    assign w_ctl.upd  = (r_state == S_UPD) && (w_hit || r_op);
    assign w_ctl.mode = w_mode;
    assign w_ctl.key  = r_key;

    // Word entering the head cell
    assign w_head.vld = 1'b1;
    assign w_head.key = r_key;
    assign w_head.val = r_op ? r_value : w_ch[0].rd;

    // Row of cells, head at index 0
    assign w_ch[ENTRIES] = '0;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkvc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  ((g == 0) ? w_head : w_ent[(g == 0) ? 0 : g-1]),
            .i_right (w_ch[g+1]),
            .o_entry (w_ent[g]),
            .o_chain (w_ch[g]),
            .o_match (w_match[g])
        );
        assign w_vld[g] = w_ent[g].vld;
    end

    // Sequencer, command latch, fill count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
            r_hit    <= 1'b0;
            r_rd     <= '0;
            r_ev     <= 1'b0;
            r_evk    <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_strobe <= 1'b1;
                    r_hit    <= w_hit;
                    r_rd     <= (!r_op && w_hit) ? w_ch[0].rd : '0;
                    r_ev     <= r_op && (w_mode == MODE_EVICT);
                    r_evk    <= (r_op && (w_mode == MODE_EVICT)) ? w_ch[0].lkey : '0;
                    if (r_op && (w_mode == MODE_INS)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_state  <= w_accept ? S_CMP : S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_accept) begin
                r_op    <= i_op;
                r_key   <= i_key;
                r_value <= i_value;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_hit         = r_hit;
    assign o_read_value  = r_rd;
    assign o_evicted     = r_ev;
    assign o_evicted_key = r_evk;

    // Keys are unique, so at most one cell matches
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_match))
        else $error("several cells match one key");

    // Valid cells and fill count agree
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == int'(r_fill))
        else $error("fill count differs from valid cells");

    // Valid cells form an unbroken run from the head
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld & (w_vld + ENTRIES'(1))) == '0))
        else $error("gap in the valid cells");

    // Eviction only on a put that missed
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_evicted) |-> (!o_hit && $past(r_op)))
        else $error("eviction without a missing put");

    // Every accepted command yields a strobe
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_strobe)
        else $error("result strobe missing");

endmodule

/* hdl/lkvc_cell.sv */
// One cache cell: holds an entry, compares it against the lookup key and
// takes its left neighbour's word when the row shifts.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_left,
    input  t_chain    i_right,
    output t_entry    o_entry,
    output t_chain    o_chain,
    output logic      o_match
);

    logic             r_vld;
    logic             r_match;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic             w_take;

    // Shift condition: cell position is at or left of the hole being filled
    always_comb begin
        case (i_ctl.mode)
            MODE_HIT:   w_take = r_match | i_right.any;
            MODE_INS:   w_take = i_left.vld;
            MODE_EVICT: w_take = r_vld;
            default:    w_take = 1'b0;
        endcase
    end

    // Control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= r_vld && (r_key == i_ctl.key);
            end
            if (i_ctl.upd && w_take) begin
                r_vld <= i_left.vld;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && w_take) begin
            r_key <= i_left.key;
            r_val <= i_left.val;
        end
    end

    assign o_entry = '{vld: r_vld, key: r_key, val: r_val};

    // Summary towards the head
    assign o_chain.any      = r_match | i_right.any;
    assign o_chain.next_vld = r_vld;
    assign o_chain.rd       = i_right.rd | (r_match ? r_val : '0);
    assign o_chain.lkey     = i_right.lkey | ((r_vld && !i_right.next_vld) ? r_key : '0);
    assign o_match          = r_match;

endmodule

/* dv/tb_lru_key_value_cache.sv */
// Self-checking testbench for lru_key_value_cache: drives get/put command
// words, predicts every result with a recency-ordered entry list and checks it.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int ENTRY_COUNT = DEF_ENTRIES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    // One cached entry as the predictor keeps it
    typedef struct {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_line;

    // One predicted result word
    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_outcome;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_op = 1'b0;
    logic signed [KEY_W-1:0] i_key = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_strobe;
    logic                    o_hit;
    logic signed [VAL_W-1:0] o_read_value;
    logic                    o_evicted;
    logic signed [KEY_W-1:0] o_evicted_key;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic        [CFG_W-1:0] i_cfg_active_entries = '0;

    // Predictor state: front of the list is the most recent entry
    t_line    recency_list[$];
    int       capacity_now = ENTRY_COUNT;
    t_outcome pending_results[$];

    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key_corners[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    bit steady_phase = 1'b0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int hits_seen      = 0;
    int evictions_seen = 0;
    int words_sent     = 0;
    int gets_sent      = 0;
    int puts_sent      = 0;
    int capacity_writes = 0;

    lru_key_value_cache uut (.*);

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch on result %0d: %s got %h want %h",
                     results_seen, what, got, want);
    endtask

    // Apply one command word to the predicted cache and return its result
    function automatic t_outcome cache_access(input t_op op, input logic [KEY_W-1:0] key,
                                              input logic [VAL_W-1:0] val);
        t_outcome res;
        t_line    ln;
        int       idx;
        res = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
        idx = -1;
        foreach (recency_list[i])
            if (idx < 0 && recency_list[i].key == key) idx = i;
        if (idx >= 0) begin
            // hit: read or overwrite, then move to the head
            ln = recency_list[idx];
            res.hit = 1'b1;
            if (op == OP_GET) res.read_value = ln.val;
            else ln.val = val;
            recency_list.delete(idx);
            recency_list.push_front(ln);
        end else if (op == OP_PUT) begin
            // miss on put: drop the oldest once at or over capacity
            if (recency_list.size() >= capacity_now) begin
                ln = recency_list.pop_back();
                res.evicted = 1'b1;
                res.evicted_key = ln.key;
            end
            ln.key = key;
            ln.val = val;
            recency_list.push_front(ln);
        end
        return res;
    endfunction

    // Mostly back to back (always in a steady phase), some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one command word and record its prediction
    task automatic send_word(input t_op op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        int gap;
        start   <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_value <= val;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(cache_access(op, key, val));
        words_sent++;
        if (op == OP_GET) gets_sent++;
        else puts_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted result has arrived, then let the row settle
    task automatic wait_until_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Capacity write; only called with the cache idle
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        i_cfg_valid          <= 1'b1;
        i_cfg_active_entries <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity_now = (cap < 1) ? 1 : ((cap > ENTRY_COUNT) ? ENTRY_COUNT : int'(cap));
        capacity_writes++;
    endtask

    // Result checker: compare each strobed word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word, hit", 32'(o_hit), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch("hit", 32'(o_hit), 32'(want.hit));
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", o_read_value, want.read_value);
                if (o_evicted !== want.evicted)
                    report_mismatch("evicted", 32'(o_evicted), 32'(want.evicted));
                if (o_evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", o_evicted_key, want.evicted_key);
                if (want.hit) hits_seen++;
                if (want.evicted) evictions_seen++;
            end
        end
    end

    // Lookups on an empty cache all miss
    task automatic test_empty_lookup();
        send_word(OP_GET, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_GET, 32'h8000_0000, 32'h0);
        send_word(OP_GET, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // Extreme keys and values, read back, then an overwrite of a present key
    task automatic test_field_extremes();
        send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_PUT, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_PUT, 32'hFFFF_FFFF, 32'h0);
        foreach (key_corners[i]) send_word(OP_GET, key_corners[i], 32'h0);
        send_word(OP_PUT, 32'h0, 32'h0000_0005);
        send_word(OP_GET, 32'h0, 32'hFFFF_FFFF);
    endtask

    // Capacity 0 acts as 1 and sits below the fill; 31 is clipped to 16
    task automatic test_capacity_corners();
        wait_until_drained();
        write_capacity(5'd0);
        send_word(OP_PUT, 32'h1234_5678, 32'h1);
        send_word(OP_GET, 32'h8000_0000, 32'h0);
        send_word(OP_PUT, 32'h0F0F_0F0F, 32'h2);
        send_word(OP_GET, 32'h1234_5678, 32'h0);
        wait_until_drained();
        write_capacity(5'd31);
        send_word(OP_PUT, 32'h5555_AAAA, 32'h3);
        send_word(OP_GET, 32'h5555_AAAA, 32'h0);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 95) return $urandom;
        return key_corners[$urandom_range(0, 3)];
    endfunction

    // One random phase: keys from a pool as large as the capacity or a little larger,
    // so hits, refills and evictions all come up
    task automatic run_random_phase(input logic [CFG_W-1:0] cap, input int count);
        int   pool_size;
        t_op  op;
        wait_until_drained();
        write_capacity(cap);
        pool_size = capacity_now + $urandom_range(0, capacity_now / 2 + 3);
        key_pool.delete();
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back(($urandom_range(0, 9) == 0) ? key_corners[$urandom_range(0, 3)]
                                                           : $urandom);
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 99) < 50) ? OP_PUT : OP_GET;
            send_word(op, pick_key(), $urandom);
            if (i == count / 2 && $urandom_range(0, 1) == 0) wait_until_drained();
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] caps[10] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17,
                                        5'd4, 5'd12, 5'd16};
        caps[9] = CFG_W'($urandom_range(0, 31));
        foreach (caps[p]) begin
            steady_phase = (p % 3 == 1);
            run_random_phase(caps[p], 110);
        end
        steady_phase = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_lookup();
        test_field_extremes();
        test_capacity_corners();
        test_random_traffic();

        wait_until_drained();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d command words (%0d gets, %0d puts) across %0d capacity settings.",
                 words_sent, gets_sent, puts_sent, capacity_writes);
        $display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches.",
                 results_seen, hits_seen, evictions_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
